// ===== rtl/core/sdc_pkg.sv =====
// Shared types, widths and constants of the serial date to calendar converter.
package sdc_pkg;

    // Field widths of the input and result words
    localparam int DayNumW  = 23;
    localparam int YearW    = 14;
    localparam int MonthW   = 4;
    localparam int DomW     = 5;
    localparam int DoyW     = 9;
    localparam int WdayW    = 3;

    // Configuration port
    localparam int ApbAddrW = 3;
    localparam int ApbDataW = 32;
    localparam int WsdW     = 3;
    localparam logic [WsdW-1:0] WsdReset = 3'd1;

    // Shared divider geometry; reciprocals are scaled by 2^DivNumW
    localparam int DivNumW = 22;
    localparam int DivDenW = 18;
    localparam int DivRcpW = 20;

    // Valid serial range (years 100 to 9999)
    localparam logic signed [DayNumW-1:0] SerialMin = -23'sd657434;
    localparam logic signed [DayNumW-1:0] SerialMax = 23'sd2958465;

    // Offset from serial day to days since 0000-03-01
    localparam logic signed [DayNumW:0] MarchShift = 24'sd693899;

    // Divisors used by the sequencer
    localparam logic [DivDenW-1:0] DenEra    = 18'd146097;
    localparam logic [DivDenW-1:0] Den4Yr    = 18'd1460;
    localparam logic [DivDenW-1:0] DenCent   = 18'd36524;
    localparam logic [DivDenW-1:0] DenYear   = 18'd365;
    localparam logic [DivDenW-1:0] Den100    = 18'd100;
    localparam logic [DivDenW-1:0] DenMonth  = 18'd153;
    localparam logic [DivDenW-1:0] DenWeek   = 18'd7;
    localparam logic [DivDenW-1:0] LastDoe   = 18'd146096;

    // Rounded-down reciprocals of the divisors, floor(2^22 / divisor)
    localparam logic [DivRcpW-1:0] RcpEra    = 20'd28;
    localparam logic [DivRcpW-1:0] Rcp4Yr    = 20'd2872;
    localparam logic [DivRcpW-1:0] RcpCent   = 20'd114;
    localparam logic [DivRcpW-1:0] RcpYear   = 20'd11491;
    localparam logic [DivRcpW-1:0] Rcp100    = 20'd41943;
    localparam logic [DivRcpW-1:0] RcpMonth  = 20'd27413;
    localparam logic [DivRcpW-1:0] RcpWeek   = 20'd599186;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERA,
        ST_D4YR,
        ST_DCENT,
        ST_YOE,
        ST_D100,
        ST_DOY,
        ST_MP,
        ST_DOW,
        ST_FIN
    } t_sdc_state;

    // Steps of the shared divider
    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RECIP,
        DIV_BACK,
        DIV_FIX
    } t_div_phase;

    // Request to and response from the shared divider
    typedef struct packed {
        logic               start;
        logic [DivNumW-1:0] num;
        logic [DivDenW-1:0] den;
        logic [DivRcpW-1:0] rcp;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [DivNumW-1:0] quot;
        logic [DivDenW-1:0] rem;
    } t_div_rsp;

    // First day of a March-based month, counted from March 1
    function automatic logic [DoyW-1:0] month_start(input logic [3:0] mp);
        logic [DoyW-1:0] v;
        case (mp)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd92;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd153;
            4'd6:    v = 9'd184;
            4'd7:    v = 9'd214;
            4'd8:    v = 9'd245;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd306;
            4'd11:   v = 9'd337;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/sdc_if.sv =====
// Valid/ready channel interfaces for the day number input and the date result.
interface sdc_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [sdc_pkg::DayNumW-1:0]  day_number;

    modport source (output valid, output day_number, input ready);
    modport sink   (input valid, input day_number, output ready);
endinterface

interface sdc_out_if;
    logic                          valid;
    logic                          ready;
    logic [sdc_pkg::YearW-1:0]     year_value;
    logic [sdc_pkg::MonthW-1:0]    month_value;
    logic [sdc_pkg::DomW-1:0]      day_of_month;
    logic [sdc_pkg::DoyW-1:0]      day_in_year;
    logic [sdc_pkg::WdayW-1:0]     weekday_value;
    logic                          out_of_range;

    modport source (output valid, output year_value, output month_value, output day_of_month,
                    output day_in_year, output weekday_value, output out_of_range,
                    input ready);
    modport sink   (input valid, input year_value, input month_value, input day_of_month,
                    input day_in_year, input weekday_value, input out_of_range,
                    output ready);
endinterface

// ===== rtl/core/serial_date_to_calendar.sv =====
// Top level: sequencer that converts a serial day number to a calendar date.
//
// Usage: a day number word enters on i_day (valid/ready) and one date word
// leaves on o_date (valid/ready). The first day of the week is written over
// the APB port at address 0 (reset value 1, Sunday; 0 also means Sunday).
// Each word is worked through seven constant divisions on one shared
// multiply unit (reciprocal multiply, multiply back, one correction), plus
// one step for the day of the year. A day number outside years 100 to 9999
// skips the divisions and gives out_of_range with all other fields zero.
// i_day.ready is high only while the sequencer is idle, so a new word is
// not taken before the last result has been loaded into the output register.
// A finished word sits in an output register; the next input word is
// accepted while it waits, and if the receiver still stalls when the next
// result is ready, the sequencer holds in its final step until the register
// frees. Reset (synchronous, active low) empties the sequencer and the
// output register and restores the week start register.
module serial_date_to_calendar (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    sdc_in_if.sink                        i_day,
    sdc_out_if.source                     o_date,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sdc_pkg::ApbAddrW-1:0]  paddr,
    input  logic [sdc_pkg::ApbDataW-1:0]  pwdata,
    output logic [sdc_pkg::ApbDataW-1:0]  prdata,
    output logic                          pready
);
    import sdc_pkg::*;

    t_sdc_state       r_state, n_state;
    logic             r_launch, n_launch;
    t_div_req         div_req;
    t_div_rsp         div_rsp;
    logic [WsdW-1:0]  week_start;

    logic                r_oor;
    logic [DivNumW-1:0]  r_z;
    logic [4:0]          r_era;
    logic [DivDenW-1:0]  r_doe;
    logic [6:0]          r_q4yr;
    logic [2:0]          r_qcent;
    logic [8:0]          r_yoe;
    logic [1:0]          r_q100;
    logic [6:0]          r_r100;
    logic [DoyW-1:0]     r_doy;
    logic [3:0]          r_mp;
    logic [2:0]          r_dow;

    logic                r_out_valid;
    logic [YearW-1:0]    r_year;
    logic [MonthW-1:0]   r_month;
    logic [DomW-1:0]     r_dom;
    logic [DoyW-1:0]     r_diy;
    logic [WdayW-1:0]    r_wday;
    logic                r_out_oor;

    logic                in_acc;
    logic                in_oor;
    logic [DayNumW:0]    z_wide;
    logic [DivDenW-1:0]  yoe_num;
    logic [DivDenW-1:0]  doy_base;
    logic [DivDenW-1:0]  doy_full;
    logic [10:0]         mp_num;
    logic                out_load;
    logic                late_month;
    logic                leap;
    logic [YearW-1:0]    f_year;
    logic [MonthW-1:0]   f_month;
    logic [DomW-1:0]     f_dom;
    logic [DoyW-1:0]     f_diy;
    logic [2:0]          fd_m1;
    logic [3:0]          wd_t;
    logic [3:0]          wd_m;
    logic [WdayW-1:0]    f_wday;

    // Configuration register
    sdc_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_week_start (week_start)
    );

    // Shared divider
    sdc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Input decode: range check and shift to a March-based day count
    assign in_acc = i_day.valid && i_day.ready;
    assign in_oor = (i_day.day_number < SerialMin) || (i_day.day_number > SerialMax);
    assign z_wide = {i_day.day_number[DayNumW-1], i_day.day_number} + MarchShift;

    // Operand terms of the year and month divisions
    assign yoe_num  = r_doe - DivDenW'(r_q4yr) + DivDenW'(r_qcent)
                      - DivDenW'(r_doe == LastDoe);
    assign doy_base = DivDenW'(r_yoe) * DivDenW'(365) + DivDenW'(r_yoe[8:2])
                      - DivDenW'(r_q100);
    assign doy_full = r_doe - doy_base;
    assign mp_num   = 11'(r_doy) * 11'd5 + 11'd2;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (in_acc) begin
                          n_state = in_oor ? ST_FIN : ST_ERA;
                      end
            ST_ERA:   if (div_rsp.done) begin
                          n_state = ST_D4YR;
                      end
            ST_D4YR:  if (div_rsp.done) begin
                          n_state = ST_DCENT;
                      end
            ST_DCENT: if (div_rsp.done) begin
                          n_state = ST_YOE;
                      end
            ST_YOE:   if (div_rsp.done) begin
                          n_state = ST_D100;
                      end
            ST_D100:  if (div_rsp.done) begin
                          n_state = ST_DOY;
                      end
            ST_DOY:   n_state = ST_MP;
            ST_MP:    if (div_rsp.done) begin
                          n_state = ST_DOW;
                      end
            ST_DOW:   if (div_rsp.done) begin
                          n_state = ST_FIN;
                      end
            ST_FIN:   if (out_load) begin
                          n_state = ST_IDLE;
                      end
            default:  n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs: handshakes and divider operands
    always_comb begin
        i_day.ready   = (r_state == ST_IDLE);
        out_load      = (r_state == ST_FIN) && (!r_out_valid || o_date.ready);
        n_launch      = (n_state != r_state) && (n_state != ST_IDLE)
                        && (n_state != ST_DOY) && (n_state != ST_FIN);
        div_req.start = r_launch;
        div_req.num   = r_z;
        div_req.den   = DenEra;
        div_req.rcp   = RcpEra;
        case (r_state)
            ST_ERA: begin
                div_req.num = r_z;
                div_req.den = DenEra;
                div_req.rcp = RcpEra;
            end
            ST_D4YR: begin
                div_req.num = DivNumW'(r_doe);
                div_req.den = Den4Yr;
                div_req.rcp = Rcp4Yr;
            end
            ST_DCENT: begin
                div_req.num = DivNumW'(r_doe);
                div_req.den = DenCent;
                div_req.rcp = RcpCent;
            end
            ST_YOE: begin
                div_req.num = DivNumW'(yoe_num);
                div_req.den = DenYear;
                div_req.rcp = RcpYear;
            end
            ST_D100: begin
                div_req.num = DivNumW'(r_yoe);
                div_req.den = Den100;
                div_req.rcp = Rcp100;
            end
            ST_MP: begin
                div_req.num = DivNumW'(mp_num);
                div_req.den = DenMonth;
                div_req.rcp = RcpMonth;
            end
            ST_DOW: begin
                div_req.num = r_z + DivNumW'(3);
                div_req.den = DenWeek;
                div_req.rcp = RcpWeek;
            end
            default: begin
                div_req.num = r_z;
                div_req.den = DenEra;
                div_req.rcp = RcpEra;
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_launch <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_launch <= n_launch;
        end
    end

    // Intermediate results captured from the divider
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_oor <= in_oor;
            r_z   <= z_wide[DivNumW-1:0];
        end
        if (div_rsp.done) begin
            case (r_state)
                ST_ERA: begin
                    r_era <= div_rsp.quot[4:0];
                    r_doe <= div_rsp.rem;
                end
                ST_D4YR:  r_q4yr  <= div_rsp.quot[6:0];
                ST_DCENT: r_qcent <= div_rsp.quot[2:0];
                ST_YOE:   r_yoe   <= div_rsp.quot[8:0];
                ST_D100: begin
                    r_q100 <= div_rsp.quot[1:0];
                    r_r100 <= div_rsp.rem[6:0];
                end
                ST_MP:    r_mp  <= div_rsp.quot[3:0];
                ST_DOW:   r_dow <= div_rsp.rem[2:0];
                default: begin
                end
            endcase
        end
        if (r_state == ST_DOY) begin
            r_doy <= doy_full[DoyW-1:0];
        end
    end

    // Final assembly: January and February belong to the next civil year
    always_comb begin
        late_month = (r_mp >= 4'd10);
        leap       = ((r_yoe[1:0] == 2'd0) && (r_r100 != 7'd0)) || (r_yoe == 9'd0);
        f_year     = YearW'(r_era) * YearW'(400) + YearW'(r_yoe) + YearW'(late_month);
        f_month    = late_month ? r_mp - 4'd9 : r_mp + 4'd3;
        f_dom      = DomW'(r_doy - month_start(r_mp) + 9'd1);
        f_diy      = late_month ? r_doy - 9'd305 : r_doy + 9'd60 + DoyW'(leap);
        fd_m1      = (week_start == '0) ? 3'd0 : week_start - 3'd1;
        wd_t       = {1'b0, r_dow} + 4'd7 - {1'b0, fd_m1};
        wd_m       = (wd_t >= 4'd7) ? wd_t - 4'd7 : wd_t;
        f_wday     = wd_m[2:0] + 3'd1;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_date.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_oor <= r_oor;
            r_year    <= r_oor ? '0 : f_year;
            r_month   <= r_oor ? '0 : f_month;
            r_dom     <= r_oor ? '0 : f_dom;
            r_diy     <= r_oor ? '0 : f_diy;
            r_wday    <= r_oor ? '0 : f_wday;
        end
    end

    assign o_date.valid         = r_out_valid;
    assign o_date.year_value    = r_year;
    assign o_date.month_value   = r_month;
    assign o_date.day_of_month  = r_dom;
    assign o_date.day_in_year   = r_diy;
    assign o_date.weekday_value = r_wday;
    assign o_date.out_of_range  = r_out_oor;

endmodule

// ===== rtl/core/sdc_cfg.sv =====
// APB register block holding the first day of the week.
module sdc_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sdc_pkg::ApbAddrW-1:0]  paddr,
    input  logic [sdc_pkg::ApbDataW-1:0]  pwdata,
    output logic [sdc_pkg::ApbDataW-1:0]  prdata,
    output logic                          pready,
    output logic [sdc_pkg::WsdW-1:0]      o_week_start
);
    import sdc_pkg::*;

    logic [WsdW-1:0] r_week_start;
    logic            wr_hit;

    // Register 0 is the only one; bit 2 selects the next word address.
    assign wr_hit = psel && penable && pwrite && !paddr[2];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_week_start <= WsdReset;
        end else if (wr_hit) begin
            r_week_start <= pwdata[WsdW-1:0];
        end
    end

    // Read back; unmapped addresses read as zero.
    always_comb begin
        prdata = '0;
        if (!paddr[2]) begin
            prdata = {{(ApbDataW-WsdW){1'b0}}, r_week_start};
        end
    end

    assign o_week_start = r_week_start;

endmodule

// ===== rtl/core/sdc_div.sv =====
// Shared divide-by-constant unit: reciprocal multiply, multiply back and one correction.
module sdc_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sdc_pkg::t_div_req   i_req,
    output sdc_pkg::t_div_rsp   o_rsp
);
    import sdc_pkg::*;

    t_div_phase                  r_phase, n_phase;
    logic                        r_done;
    logic [DivNumW-1:0]          r_num;
    logic [DivDenW-1:0]          r_den;
    logic [DivRcpW-1:0]          r_rcp;
    logic [DivNumW-1:0]          r_quot;
    logic [DivNumW-1:0]          r_rem;
    logic [DivNumW-1:0]          mul_a;
    logic [DivRcpW-1:0]          mul_b;
    logic [DivNumW+DivRcpW-1:0]  prod;
    logic                        fix_up;

    // Next phase: one step per cycle after a start
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            DIV_IDLE:  if (i_req.start) begin
                           n_phase = DIV_RECIP;
                       end
            DIV_RECIP: n_phase = DIV_BACK;
            DIV_BACK:  n_phase = DIV_FIX;
            DIV_FIX:   n_phase = DIV_IDLE;
            default:   n_phase = DIV_IDLE;
        endcase
    end

    // Multiplier operands: numerator times reciprocal, then estimate times divisor.
    // The estimate is low by at most one, so one compare and subtract finishes it.
    always_comb begin
        mul_a = r_num;
        mul_b = r_rcp;
        case (r_phase)
            DIV_BACK: begin
                mul_a = r_quot;
                mul_b = {{(DivRcpW-DivDenW){1'b0}}, r_den};
            end
            default: begin
                mul_a = r_num;
                mul_b = r_rcp;
            end
        endcase
        fix_up = (r_rem >= {{(DivNumW-DivDenW){1'b0}}, r_den});
    end

    assign prod = mul_a * mul_b;

    // Phase and completion pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= DIV_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_done  <= (r_phase == DIV_FIX);
        end
    end

    // Operand capture, quotient estimate, remainder and correction
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.num;
            r_den <= i_req.den;
            r_rcp <= i_req.rcp;
        end else begin
            case (r_phase)
                DIV_RECIP: begin
                    r_quot <= {{(DivNumW-DivRcpW){1'b0}},
                               prod[DivNumW+DivRcpW-1:DivNumW]};
                end
                DIV_BACK: begin
                    r_rem <= r_num - prod[DivNumW-1:0];
                end
                DIV_FIX: begin
                    if (fix_up) begin
                        r_quot <= r_quot + DivNumW'(1);
                        r_rem  <= r_rem - {{(DivNumW-DivDenW){1'b0}}, r_den};
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
    assign o_rsp.rem  = r_rem[DivDenW-1:0];

endmodule

// ===== rtl/core/sdc_chk.sv =====
// Port-level checks of the date converter, bound to the top level.
module sdc_chk (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [sdc_pkg::YearW-1:0]    i_year,
    input logic [sdc_pkg::MonthW-1:0]   i_month,
    input logic [sdc_pkg::DomW-1:0]     i_dom,
    input logic [sdc_pkg::DoyW-1:0]     i_diy,
    input logic [sdc_pkg::WdayW-1:0]    i_wday,
    input logic                         i_oor
);

    // A stalled result word stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped while stalled");

    // One word at a time: after an accept the input side closes.
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input accepted while a word is in work");

    // An out-of-range word carries no date.
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_oor |-> (i_year == '0) && (i_month == '0) && (i_dom == '0)
                                 && (i_diy == '0) && (i_wday == '0))
        else $error("out-of-range word has nonzero fields");

    // A valid date has nonzero day, day of year and weekday, a month from 1 to 12 and a year of at least 100.
    a_date_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_oor |-> (i_month != '0) && (i_month <= 4'd12) && (i_dom != '0)
                                  && (i_wday != '0) && (i_diy != '0) && (i_year >= 14'd100))
        else $error("date fields out of range");

endmodule

bind serial_date_to_calendar sdc_chk u_sdc_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_day.valid),
    .i_in_ready  (i_day.ready),
    .i_out_valid (o_date.valid),
    .i_out_ready (o_date.ready),
    .i_year      (o_date.year_value),
    .i_month     (o_date.month_value),
    .i_dom       (o_date.day_of_month),
    .i_diy       (o_date.day_in_year),
    .i_wday      (o_date.weekday_value),
    .i_oor       (o_date.out_of_range)
);
